// ===== rtl/core/mexp_pkg.sv =====
// shared constants and types for the modular exponentiation block
package mexp_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int CNT_W      = $clog2(DATA_WIDTH + 1);
  localparam int NUM_REGS   = 2;
  localparam int IDX_W      = 2;

  typedef logic [DATA_WIDTH-1:0] word_t;
  typedef logic [DATA_WIDTH:0]   wide_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [IDX_W-1:0]      reg_idx_t;

  localparam reg_idx_t REG_PRIVATE_EXPONENT = IDX_W'(0);
  localparam reg_idx_t REG_KEY_MODULUS      = IDX_W'(1);

  typedef struct packed {
    logic  start;
    word_t a;
    word_t b;
    word_t n;
  } mm_req_t;

  typedef struct packed {
    logic  busy;
    logic  done;
    word_t result;
  } mm_rsp_t;

endpackage

// ===== rtl/core/mexp_stream_if.sv =====
// valid/ready stream interfaces for ciphertext and plaintext words
interface mexp_cipher_if;
  import mexp_pkg::*;
  logic  valid;
  logic  ready;
  word_t cipher_word;
  modport source (output valid, output cipher_word, input ready);
  modport sink (input valid, input cipher_word, output ready);
endinterface

interface mexp_plain_if;
  import mexp_pkg::*;
  logic  valid;
  logic  ready;
  word_t plain_word;
  modport source (output valid, output plain_word, input ready);
  modport sink (input valid, input plain_word, output ready);
endinterface

// ===== rtl/core/mexp_modmul.sv =====
// iterative shift-and-add modular multiplier, one adder reused for a double and an add step per bit
module mexp_modmul (
  input  logic              clk,
  input  logic              rst,
  input  mexp_pkg::mm_req_t req,
  output mexp_pkg::mm_rsp_t rsp
);
  import mexp_pkg::*;

  typedef enum logic [1:0] {MM_IDLE, MM_DBL, MM_ADD} mm_state_t;

  mm_state_t state;
  word_t     a;
  word_t     bsh;
  word_t     n;
  word_t     r;
  cnt_t      cnt;
  logic      done;

  word_t operand;
  wide_t sum;
  word_t red;

  always_comb begin
    if (state == MM_DBL) begin
      operand = r;
    end else if (bsh[DATA_WIDTH-1]) begin
      operand = a;
    end else begin
      operand = '0;
    end
    sum = {1'b0, r} + {1'b0, operand};
    if (sum >= {1'b0, n}) begin
      red = DATA_WIDTH'(sum - {1'b0, n});
    end else begin
      red = sum[DATA_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= MM_IDLE;
      done  <= 1'b0;
    end else begin
      case (state)
        MM_IDLE: begin
          done <= 1'b0;
          if (req.start) begin
            a     <= req.a;
            bsh   <= req.b;
            n     <= req.n;
            r     <= '0;
            cnt   <= CNT_W'(DATA_WIDTH);
            state <= MM_DBL;
          end
        end
        MM_DBL: begin
          done  <= 1'b0;
          r     <= red;
          state <= MM_ADD;
        end
        MM_ADD: begin
          r   <= red;
          bsh <= {bsh[DATA_WIDTH-2:0], 1'b0};
          cnt <= cnt - CNT_W'(1);
          if (cnt == CNT_W'(1)) begin
            done  <= 1'b1;
            state <= MM_IDLE;
          end else begin
            done  <= 1'b0;
            state <= MM_DBL;
          end
        end
        default: begin
          done  <= 1'b0;
          state <= MM_IDLE;
        end
      endcase
    end
  end

  assign rsp.busy   = (state != MM_IDLE);
  assign rsp.done   = done;
  assign rsp.result = r;

endmodule

// ===== rtl/core/modular_exponentiation_unit.sv =====
// top level: modular exponentiation by left-to-right square-and-multiply
//
// cipher (sink) takes one ciphertext word per transaction; plain (source)
// returns cipher_word ** private_exponent mod key_modulus for each one.
// the two key registers are written through cfg_we / cfg_index / cfg_data:
// index 0 is the exponent, index 1 the modulus; other indexes are ignored.
// both reset to 1. write them only while no transaction is in flight.
// one modular multiplier is shared by every step; each multiply runs a
// double and an add step per multiplier bit. an item costs one multiply
// to reduce the ciphertext, DATA_WIDTH squares and one multiply per set
// exponent bit: (DATA_WIDTH + popcount(d) + 1) multiplies. an exponent of
// zero answers 1 and a modulus of zero answers 0, without the multiplier.
// cipher.ready is high only while the block is idle; the result sits in
// an output register until plain.ready takes it, and a finished result
// waits in S_FIN while the previous one is still held. reset drops
// plain.valid and aborts any item in progress.
module modular_exponentiation_unit (
  input  logic               clk,
  input  logic               rst,
  mexp_cipher_if.sink        cipher,
  mexp_plain_if.source       plain,
  input  logic               cfg_we,
  input  mexp_pkg::reg_idx_t cfg_index,
  input  mexp_pkg::word_t    cfg_data
);
  import mexp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_REDUCE, S_SQUARE, S_MULT, S_FIN
  } state_t;

  state_t  state;
  word_t   private_exponent;
  word_t   key_modulus;
  word_t   dsh;
  word_t   base;
  word_t   acc;
  word_t   n;
  cnt_t    bitcnt;
  word_t   out_word;
  logic    out_valid;
  mm_req_t mm_req;
  mm_rsp_t mm_rsp;

  always_ff @(posedge clk) begin
    if (rst) begin
      private_exponent <= word_t'(1);
      key_modulus      <= word_t'(1);
    end else if (cfg_we) begin
      if (cfg_index == REG_PRIVATE_EXPONENT) begin
        private_exponent <= cfg_data;
      end else if (cfg_index == REG_KEY_MODULUS) begin
        key_modulus <= cfg_data;
      end
    end
  end

  mexp_modmul u_modmul (
    .clk (clk),
    .rst (rst),
    .req (mm_req),
    .rsp (mm_rsp)
  );

  assign cipher.ready   = (state == S_IDLE);
  assign plain.valid    = out_valid;
  assign plain.plain_word = out_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      mm_req.start <= 1'b0;
    end else begin
      if (out_valid && plain.ready && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cipher.valid) begin
            dsh    <= private_exponent;
            n      <= key_modulus;
            bitcnt <= CNT_W'(DATA_WIDTH);
            if (private_exponent == '0) begin
              acc          <= word_t'(1);
              mm_req.start <= 1'b0;
              state        <= S_FIN;
            end else if (key_modulus == '0) begin
              acc          <= '0;
              mm_req.start <= 1'b0;
              state        <= S_FIN;
            end else begin
              acc          <= (key_modulus == word_t'(1)) ? '0 : word_t'(1);
              mm_req.start <= 1'b1;
              mm_req.a     <= (key_modulus == word_t'(1)) ? '0 : word_t'(1);
              mm_req.b     <= cipher.cipher_word;
              mm_req.n     <= key_modulus;
              state        <= S_REDUCE;
            end
          end else begin
            mm_req.start <= 1'b0;
          end
        end
        S_REDUCE: begin
          if (mm_rsp.done) begin
            base         <= mm_rsp.result;
            mm_req.start <= 1'b1;
            mm_req.a     <= acc;
            mm_req.b     <= acc;
            state        <= S_SQUARE;
          end else begin
            mm_req.start <= 1'b0;
          end
        end
        S_SQUARE, S_MULT: begin
          if (mm_rsp.done) begin
            acc <= mm_rsp.result;
            if (state == S_SQUARE && dsh[DATA_WIDTH-1]) begin
              mm_req.start <= 1'b1;
              mm_req.a     <= mm_rsp.result;
              mm_req.b     <= base;
              state        <= S_MULT;
            end else begin
              dsh    <= {dsh[DATA_WIDTH-2:0], 1'b0};
              bitcnt <= bitcnt - CNT_W'(1);
              if (bitcnt == CNT_W'(1)) begin
                mm_req.start <= 1'b0;
                state        <= S_FIN;
              end else begin
                mm_req.start <= 1'b1;
                mm_req.a     <= mm_rsp.result;
                mm_req.b     <= mm_rsp.result;
                state        <= S_SQUARE;
              end
            end
          end else begin
            mm_req.start <= 1'b0;
          end
        end
        S_FIN: begin
          mm_req.start <= 1'b0;
          if (!out_valid || plain.ready) begin
            out_word  <= acc;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          mm_req.start <= 1'b0;
          state        <= S_IDLE;
        end
      endcase
    end
  end

  a_start_when_free: assert property (@(posedge clk) disable iff (rst)
    mm_req.start |-> !mm_rsp.busy)
    else $error("multiplier started while busy");

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    mm_rsp.done |-> (state == S_REDUCE || state == S_SQUARE || state == S_MULT))
    else $error("multiplier finished outside a wait state");

  a_result_reduced: assert property (@(posedge clk) disable iff (rst)
    mm_rsp.done |-> (mm_rsp.result < n))
    else $error("multiplier result not below modulus");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !plain.ready) |=> out_valid)
    else $error("pending result dropped");

endmodule
